// File: design/tpc_pkg.sv
// tpc_pkg: shared constants, codes and types of the tap/press classifier
// used by tpc_divider and tap_press_classifier; no dependencies
package tpc_pkg;

  // widths of the payload and config port
  localparam int unsigned StampW  = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned KindW   = 2;
  localparam int unsigned UnitsW  = 6;

  // largest press count that is reported without overflow
  localparam int unsigned MaxUnits = 50;

  // result kinds
  localparam logic [KindW-1:0] KIND_NONE  = 2'd0;
  localparam logic [KindW-1:0] KIND_TAP   = 2'd1;
  localparam logic [KindW-1:0] KIND_PRESS = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_TAP_SPAN   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LIM  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_STEP = 4'd3;

  // register reset values
  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] TapSpanRst   = 16'd300;
  localparam logic [CfgW-1:0] PressLimRst  = 16'd500;
  localparam logic [CfgW-1:0] PressStepRst = 16'd1000;

  // status of the step counting unit
  typedef struct packed {
    logic busy;
    logic done;
    logic overflow;
  } div_status_t;

endpackage

// File: design/tpc_divider.sv
// tpc_divider: counts press steps, ceil(excess / step) capped at MaxUnits,
// by one compare-and-subtract per cycle; depends on tpc_pkg
module tpc_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tpc_pkg::StampW-1:0]    excess_i,
  input  logic [tpc_pkg::CfgW-1:0]      step_i,
  output tpc_pkg::div_status_t          status_o,
  output logic [tpc_pkg::UnitsW-1:0]    units_o
);
  import tpc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                ovf_q, ovf_d;
  logic [StampW-1:0]   rem_q, rem_d;
  logic [CfgW-1:0]     step_q, step_d;
  logic [UnitsW-1:0]   count_q, count_d;
  logic [StampW:0]     diff;

  // subtractor: remainder minus step, borrow means below one step
  assign diff = {1'b0, rem_q} - {{(StampW-CfgW+1){1'b0}}, step_q};

  // sequencing of the count
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    rem_d   = rem_q;
    step_d  = step_q;
    count_d = count_q;
    if (start_i) begin
      rem_d   = excess_i;
      step_d  = step_i;
      count_d = '0;
      ovf_d   = 1'b0;
      if (step_i == '0) begin
        // zero step can never reach a count
        done_d = 1'b1;
        ovf_d  = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (count_q == UnitsW'(MaxUnits)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ovf_d  = 1'b1;
      end else begin
        rem_d   = diff[StampW] ? '0 : diff[StampW-1:0];
        count_d = count_q + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ovf_q   <= ovf_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    count_q <= count_d;
  end

  assign status_o.busy     = busy_q;
  assign status_o.done     = done_q;
  assign status_o.overflow = ovf_q;
  assign units_o           = count_q;

endmodule

// File: design/tap_press_classifier.sv
// tap_press_classifier: top level, sample sequencer, held-time state and config
// depends on tpc_pkg and tpc_divider
//
// One result is produced for each accepted button sample. The block takes one
// sample at a time. On its way from accept to result register, a released
// sample passes ST_DELTA, ST_EVAL and ST_RES, and a held sample at or below
// the press threshold passes ST_DELTA, ST_ADD, ST_EVAL and ST_RES. A long
// press also waits in ST_DIV, where the divider counts press steps one per
// cycle, up to 50 steps, then checks the cap and flags done; a zero press step
// ends at once. The result sits in an output register, and the next sample is
// accepted while it waits to be taken.
// Config writes land at once and should only be issued while the block is idle.
module tap_press_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           button_level_i,
  input  logic [tpc_pkg::StampW-1:0]     time_stamp_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tpc_pkg::KindW-1:0]      press_kind_o,
  output logic [tpc_pkg::UnitsW-1:0]     press_units_o,
  output logic                           units_overflow_o,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tpc_pkg::CfgW-1:0]       cfg_data_i
);
  import tpc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DELTA = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_RES   = 3'd5;

  logic [2:0]         state_q, state_d;

  logic [CfgW-1:0]    debounce_q, tap_span_q, press_lim_q, press_step_q;

  logic               level_q;
  logic [StampW-1:0]  stamp_q;
  logic [StampW-1:0]  last_stamp_q;
  logic [StampW-1:0]  held_q;
  logic [StampW-1:0]  delta_q;

  logic [KindW-1:0]   res_kind_q;
  logic [UnitsW-1:0]  res_units_q;
  logic               res_ovf_q;

  logic               out_valid_q;
  logic [KindW-1:0]   out_kind_q;
  logic [UnitsW-1:0]  out_units_q;
  logic               out_ovf_q;

  logic               in_fire;
  logic               out_free;
  logic [StampW:0]    stamp_diff;
  logic [StampW:0]    held_sum;
  logic [StampW:0]    excess_diff;
  logic [CfgW:0]      tap_top;
  logic               tap_hit;
  logic               div_start;
  div_status_t        div_status;
  logic [UnitsW-1:0]  div_units;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // forward step of the stamp, borrow means backward
  assign stamp_diff  = {1'b0, stamp_q} - {1'b0, last_stamp_q};
  // saturating held-time sum
  assign held_sum    = {1'b0, held_q} + {1'b0, delta_q};
  // amount held beyond the press threshold
  assign excess_diff = {1'b0, held_q} - {{(StampW-CfgW+1){1'b0}}, press_lim_q};
  // tap window on release
  assign tap_top     = {1'b0, debounce_q} + {1'b0, tap_span_q};
  assign tap_hit     = (held_q > {{(StampW-CfgW){1'b0}}, debounce_q}) &&
                       ({1'b0, held_q} <= {{(StampW-CfgW){1'b0}}, tap_top});

  assign div_start = (state_q == ST_EVAL) && level_q &&
                     !excess_diff[StampW] && (excess_diff != '0);

  tpc_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .excess_i (excess_diff[StampW-1:0]),
    .step_i   (press_step_q),
    .status_o (div_status),
    .units_o  (div_units)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_DELTA;
      ST_DELTA: state_d = level_q ? ST_ADD : ST_EVAL;
      ST_ADD:   state_d = ST_EVAL;
      ST_EVAL:  state_d = div_start ? ST_DIV : ST_RES;
      ST_DIV:   if (div_status.done) state_d = ST_RES;
      ST_RES:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control state, config registers and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      debounce_q   <= DebounceRst;
      tap_span_q   <= TapSpanRst;
      press_lim_q  <= PressLimRst;
      press_step_q <= PressStepRst;
      last_stamp_q <= '0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // config write
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE:   debounce_q   <= cfg_data_i;
          REG_TAP_SPAN:   tap_span_q   <= cfg_data_i;
          REG_PRESS_LIM:  press_lim_q  <= cfg_data_i;
          REG_PRESS_STEP: press_step_q <= cfg_data_i;
          default:        ;
        endcase
      end
      // stamp always follows the sample
      if (state_q == ST_DELTA) begin
        last_stamp_q <= stamp_q;
      end
      // held time grows while pressed and clears on release
      if (state_q == ST_ADD) begin
        held_q <= held_sum[StampW] ? '1 : held_sum[StampW-1:0];
      end
      if ((state_q == ST_EVAL) && !level_q) begin
        held_q <= '0;
      end
      // output register
      if ((state_q == ST_RES) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      level_q <= button_level_i;
      stamp_q <= time_stamp_i;
    end
    if (state_q == ST_DELTA) begin
      delta_q <= stamp_diff[StampW] ? '0 : stamp_diff[StampW-1:0];
    end
    if (state_q == ST_EVAL) begin
      res_units_q <= '0;
      res_ovf_q   <= 1'b0;
      if (level_q) begin
        res_kind_q <= div_start ? KIND_PRESS : KIND_NONE;
      end else begin
        res_kind_q <= tap_hit ? KIND_TAP : KIND_NONE;
      end
    end
    if ((state_q == ST_DIV) && div_status.done) begin
      res_ovf_q   <= div_status.overflow;
      res_units_q <= div_status.overflow ? '0 : div_units;
    end
    if ((state_q == ST_RES) && out_free) begin
      out_kind_q  <= res_kind_q;
      out_units_q <= res_units_q;
      out_ovf_q   <= res_ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign press_kind_o     = out_kind_q;
  assign press_units_o    = out_units_q;
  assign units_overflow_o = out_ovf_q;

endmodule

// File: dv/tb_tap_press_classifier.sv
// tb_tap_press_classifier: self-checking bench for the tap/long-press classifier
// drives button samples and config writes, expects table results for known directed rows, else in-bench predictions
// depends on tpc_pkg and tap_press_classifier
module tb_tap_press_classifier;
  import tpc_pkg::*;

  localparam int          NumDirRows   = 26;
  localparam int          NumPresets   = 5;
  localparam int          NumPhases    = 11;
  localparam int          PhaseItems   = 152;
  localparam int          HoldCycles   = 400;
  localparam int          SettleCycles = 64;
  localparam int unsigned CycleLimit   = 1000000;

  // preset selectors for the directed table
  localparam int SetKeep  = -1;
  localparam int SetReset = 0;
  localparam int SetZero  = 1;
  localparam int SetMax   = 2;
  localparam int SetFine  = 3;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [UnitsW-1:0] units;
    logic              ovf;
  } press_result_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce;
    logic [CfgW-1:0] tap;
    logic [CfgW-1:0] limit;
    logic [CfgW-1:0] step;
  } cfg_set_t;

  typedef struct packed {
    int                set_sel;
    logic              level;
    logic [StampW-1:0] stamp;
    logic              known;
    press_result_t     res;
  } tap_case_t;

  localparam press_result_t ResNone = '{KIND_NONE, 6'd0, 1'b0};
  localparam press_result_t ResTap  = '{KIND_TAP, 6'd0, 1'b0};
  localparam press_result_t ResOvf  = '{KIND_PRESS, 6'd0, 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic button_level_i = 1'b0;
  logic [StampW-1:0] time_stamp_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [KindW-1:0] press_kind_o;
  logic [UnitsW-1:0] press_units_o;
  logic units_overflow_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  // in-bench copy of the config and the held-time state
  logic [CfgW-1:0]   deb_ms   = DebounceRst;
  logic [CfgW-1:0]   tap_ms   = TapSpanRst;
  logic [CfgW-1:0]   limit_ms = PressLimRst;
  logic [CfgW-1:0]   step_ms  = PressStepRst;
  logic [StampW-1:0] held_ms    = '0;
  logic [StampW-1:0] prev_stamp = '0;

  press_result_t pending_results[$];
  logic          row_known = 1'b0;
  press_result_t row_result = ResNone;
  logic [StampW-1:0] stamp_now = '0;
  bit steady = 1'b0;
  int unsigned hold_orders = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned samples_taken = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned taps_seen = 0;
  int unsigned presses_seen = 0;
  int unsigned ovf_seen = 0;
  int unsigned settings_used = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  cfg_set_t presets [NumPresets] = '{
    '{DebounceRst, TapSpanRst, PressLimRst, PressStepRst},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd0, 16'hFFFF, 16'd0, 16'd1},
    '{16'd20, 16'd100, 16'd150, 16'd40}
  };

  // directed samples: boundaries of tap and press, stamp corner cases
  tap_case_t dir_rows [NumDirRows] = '{
    '{SetKeep, 1'b0, 32'd0,          1'b1, ResNone},
    '{SetKeep, 1'b1, 32'd10,         1'b1, ResNone},
    '{SetKeep, 1'b0, 32'd20,         1'b1, ResNone},
    '{SetKeep, 1'b1, 32'd100,        1'b1, ResNone},
    '{SetKeep, 1'b0, 32'd110,        1'b1, ResTap},
    '{SetKeep, 1'b1, 32'd460,        1'b1, ResNone},
    '{SetKeep, 1'b0, 32'd470,        1'b1, ResTap},
    '{SetKeep, 1'b1, 32'd821,        1'b1, ResNone},
    '{SetKeep, 1'b0, 32'd830,        1'b1, ResNone},
    '{SetKeep, 1'b1, 32'd1331,       1'b1, '{KIND_PRESS, 6'd1, 1'b0}},
    '{SetKeep, 1'b1, 32'd1331,       1'b1, '{KIND_PRESS, 6'd1, 1'b0}},
    '{SetKeep, 1'b1, 32'd1000,       1'b1, '{KIND_PRESS, 6'd1, 1'b0}},
    '{SetKeep, 1'b1, 32'd2000,       1'b1, '{KIND_PRESS, 6'd2, 1'b0}},
    '{SetKeep, 1'b1, 32'd50999,      1'b1, '{KIND_PRESS, 6'd50, 1'b0}},
    '{SetKeep, 1'b1, 32'd51000,      1'b1, ResOvf},
    '{SetKeep, 1'b1, 32'd0,          1'b1, ResOvf},
    '{SetKeep, 1'b1, 32'hFFFF_FFFF,  1'b1, ResOvf},
    '{SetKeep, 1'b1, 32'd5,          1'b0, ResNone},
    '{SetKeep, 1'b0, 32'hFFFF_FFFF,  1'b1, ResNone},
    '{SetZero, 1'b1, 32'd0,          1'b1, ResNone},
    '{SetKeep, 1'b1, 32'd1,          1'b1, ResOvf},
    '{SetKeep, 1'b0, 32'd2,          1'b1, ResNone},
    '{SetMax,  1'b1, 32'd65538,      1'b1, '{KIND_PRESS, 6'd1, 1'b0}},
    '{SetKeep, 1'b0, 32'd65539,      1'b1, ResTap},
    '{SetFine, 1'b1, 32'd65589,      1'b1, '{KIND_PRESS, 6'd50, 1'b0}},
    '{SetKeep, 1'b1, 32'd65590,      1'b1, ResOvf}
  };

  tap_press_classifier DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .button_level_i   (button_level_i),
    .time_stamp_i     (time_stamp_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .press_kind_o     (press_kind_o),
    .press_units_o    (press_units_o),
    .units_overflow_o (units_overflow_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicts one result and advances the held-time state
  function automatic press_result_t classify_sample(input logic lvl,
                                                    input logic [StampW-1:0] stamp);
    press_result_t r;
    logic [StampW:0] sum;
    logic [63:0] excess;
    logic [63:0] steps;
    r = ResNone;
    if (lvl) begin
      if (stamp > prev_stamp) begin
        sum = {1'b0, held_ms} + {1'b0, stamp - prev_stamp};
        held_ms = sum[StampW] ? '1 : sum[StampW-1:0];
      end
      if (held_ms > StampW'(limit_ms)) begin
        r.kind = KIND_PRESS;
        excess = 64'(held_ms) - 64'(limit_ms);
        if (step_ms == '0) begin
          r.ovf = 1'b1;
        end else begin
          steps = (excess + 64'(step_ms) - 64'd1) / 64'(step_ms);
          if (steps > 64'(MaxUnits)) r.ovf = 1'b1;
          else r.units = steps[UnitsW-1:0];
        end
      end
    end else begin
      if (held_ms > StampW'(deb_ms) &&
          33'(held_ms) <= 33'(deb_ms) + 33'(tap_ms)) r.kind = KIND_TAP;
      held_ms = '0;
    end
    prev_stamp = stamp;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // result compare and request capture, both at the rising edge
  always @(posedge clk_i) begin : result_check
    press_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, kind %0d units %0d ovf %0d", $time,
                   press_kind_o, press_units_o, units_overflow_o);
        end else begin
          want = pending_results.pop_front();
          check_field("press_kind", want.kind, press_kind_o);
          check_field("press_units", want.units, press_units_o);
          check_field("units_overflow", want.ovf, units_overflow_o);
          if (want.kind == KIND_TAP) taps_seen++;
          if (want.kind == KIND_PRESS) presses_seen++;
          if (want.ovf) ovf_seen++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = classify_sample(button_level_i, time_stamp_i);
        pending_results.push_back(row_known ? row_result : want);
        samples_taken++;
      end
    end
  end

  // result side: random stalls, steady stretch, long hold-off on request
  always @(negedge clk_i) begin
    if (hold_served != hold_orders) begin
      hold_served = hold_orders;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 37);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_tap_press_classifier: FAIL");
      $finish;
    end
  end

  // offer one sample, hold it until the request is taken
  task automatic send_sample(input logic lvl, input logic [StampW-1:0] stamp,
                             input logic known, input press_result_t res);
    int unsigned target;
    if (!steady) begin
      while ($urandom_range(0, 99) < 37) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    button_level_i <= lvl;
    time_stamp_i   <= stamp;
    row_known  = known;
    row_result = res;
    target = samples_taken + 1;
    @(negedge clk_i);
    while (samples_taken < target) @(negedge clk_i);
    samples_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one register write per cycle, the model copy follows
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_DEBOUNCE:   deb_ms = val;
      REG_TAP_SPAN:   tap_ms = val;
      REG_PRESS_LIM:  limit_ms = val;
      REG_PRESS_STEP: step_ms = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_regs(input cfg_set_t s);
    put_reg(CfgIdxW'($urandom_range(REG_PRESS_STEP + 1, 15)), CfgW'($urandom()));
    put_reg(REG_DEBOUNCE, s.debounce);
    put_reg(REG_TAP_SPAN, s.tap);
    put_reg(REG_PRESS_LIM, s.limit);
    put_reg(REG_PRESS_STEP, s.step);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_set_t random_setting();
    cfg_set_t s;
    s.debounce = ($urandom_range(0, 2) == 0) ? CfgW'($urandom()) : CfgW'($urandom_range(0, 400));
    s.tap      = ($urandom_range(0, 2) == 0) ? CfgW'($urandom()) : CfgW'($urandom_range(0, 600));
    s.limit    = ($urandom_range(0, 2) == 0) ? CfgW'($urandom()) : CfgW'($urandom_range(0, 1500));
    s.step     = ($urandom_range(0, 2) == 0) ? CfgW'($urandom()) : CfgW'($urandom_range(1, 400));
    return s;
  endfunction

  // held time to aim for: tap window edges, press step edges, or in between
  function automatic logic [StampW-1:0] pick_target();
    int unsigned deb;
    int unsigned tap;
    int unsigned lim;
    int unsigned stp;
    int unsigned k;
    deb = deb_ms;
    tap = tap_ms;
    lim = limit_ms;
    stp = (step_ms == '0) ? 1000 : step_ms;
    k = $urandom_range(0, 52);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return deb;
          1: return deb + 1;
          2: return deb + tap;
          default: return deb + tap + 1;
        endcase
      end
      1: return $urandom_range(0, deb + tap + 2);
      2: return lim + k * stp + $urandom_range(0, 2) - 1;
      default: return $urandom_range(lim, lim + 53 * stp);
    endcase
  endfunction

  // press sequence: held samples summing to the target, some cut short, then release
  task automatic held_run(input logic [StampW-1:0] total);
    int unsigned pieces;
    int unsigned cut;
    logic [StampW-1:0] left;
    logic [StampW-1:0] span;
    logic [StampW-1:0] inc;
    pieces = $urandom_range(1, 6);
    cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, pieces - 1) : pieces;
    left = total;
    for (int i = 0; i < cut; i++) begin
      if (i == pieces - 1) begin
        inc = left;
      end else begin
        span = left / (pieces - i);
        inc = $urandom_range(0, span) + $urandom_range(0, span);
        if (inc > left) inc = left;
      end
      left -= inc;
      stamp_now += inc;
      send_sample(1'b1, stamp_now, 1'b0, ResNone);
      if ($urandom_range(0, 9) == 0) send_sample(1'b1, stamp_now, 1'b0, ResNone);
    end
    stamp_now += $urandom_range(0, 3);
    send_sample(1'b0, stamp_now, 1'b0, ResNone);
  endtask

  // noise: random level, stamps jumping anywhere, forward or backward
  task automatic noise_burst();
    logic [StampW-1:0] stamp;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0: stamp = $urandom();
        1: stamp = stamp_now + $urandom_range(0, 2000);
        default: stamp = stamp_now - $urandom_range(0, 500);
      endcase
      stamp_now = stamp;
      send_sample(1'($urandom_range(0, 1)), stamp, 1'b0, ResNone);
    end
  endtask

  // main sequence
  initial begin
    int unsigned quota;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < NumDirRows; i++) begin
      if (dir_rows[i].set_sel != SetKeep) begin
        wait_all_results();
        program_regs(presets[dir_rows[i].set_sel]);
      end
      send_sample(dir_rows[i].level, dir_rows[i].stamp, dir_rows[i].known, dir_rows[i].res);
    end
    row_known = 1'b0;
    stamp_now = dir_rows[NumDirRows - 1].stamp;

    // random phases, each under its own config
    for (int p = 0; p < NumPhases; p++) begin
      wait_all_results();
      if (p < NumPresets) program_regs(presets[p]);
      else program_regs(random_setting());
      steady = (p == SetReset);
      if (p == 2 || p == 6) hold_orders++;
      quota = samples_sent + PhaseItems;
      while (samples_sent < quota) begin
        if ($urandom_range(0, 99) < 3) wait_all_results();
        if ($urandom_range(0, 99) < 80) held_run(pick_target());
        else noise_burst();
      end
    end
    steady = 1'b0;

    // drain and settle
    wait_all_results();
    repeat (SettleCycles) @(negedge clk_i);
    $display("covered %0d samples (%0d from the table) under %0d register settings",
             samples_sent, NumDirRows, settings_used);
    $display("results: %0d checked, %0d taps, %0d long presses, %0d count overflows",
             results_seen, taps_seen, presses_seen, ovf_seen);
    if (errors == 0) begin
      $display("tb_tap_press_classifier: PASS");
    end else begin
      $display("tb_tap_press_classifier: FAIL");
    end
    $finish;
  end

endmodule
